[rtl/assert_macros.svh]
// assertion macros shared by the checker files
// expects clk and rst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define CMRM_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// condition that must hold in the cycle after its trigger
`define CMRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cmrm_pkg.sv]
// shared types, constants and the scaling function of the mirror range map
// no dependencies
package cmrm_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int LINE_WIDTH_W  = 11;
    localparam int CHAN_W        = 8;
    localparam int CFG_INDEX_W   = 3;
    localparam int Q_DEPTH       = 4;

    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST     = 11'd1024;
    localparam logic [CHAN_W-1:0]       CYAN_GAIN_RST      = 8'd170;
    localparam logic [CHAN_W-1:0]       CYAN_OFFSET_RST    = 8'd85;
    localparam logic [CHAN_W-1:0]       MAGENTA_GAIN_RST   = 8'd170;
    localparam logic [CHAN_W-1:0]       MAGENTA_OFFSET_RST = 8'd30;
    localparam logic [CHAN_W-1:0]       YELLOW_GAIN_RST    = 8'd150;
    localparam logic [CHAN_W-1:0]       YELLOW_OFFSET_RST  = 8'd20;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_WIDTH,
        CFG_CYAN_GAIN,
        CFG_CYAN_OFFSET,
        CFG_MAGENTA_GAIN,
        CFG_MAGENTA_OFFSET,
        CFG_YELLOW_GAIN,
        CFG_YELLOW_OFFSET
    } cfg_idx_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef struct packed {
        logic [CHAN_W-1:0] c;
        logic [CHAN_W-1:0] m;
        logic [CHAN_W-1:0] y;
        logic              eol;
    } pix_t;

    typedef struct packed {
        logic [CHAN_W-1:0] cyan_gain;
        logic [CHAN_W-1:0] cyan_offset;
        logic [CHAN_W-1:0] magenta_gain;
        logic [CHAN_W-1:0] magenta_offset;
        logic [CHAN_W-1:0] yellow_gain;
        logic [CHAN_W-1:0] yellow_offset;
    } scale_cfg_t;

    // floor(p / 255) + offset, saturated; exact for any product of two 8-bit values
    function automatic logic [CHAN_W-1:0] scale_chan(
        input logic [2*CHAN_W-1:0] p,
        input logic [CHAN_W-1:0]   offset
    );
        logic [2*CHAN_W:0] t;
        logic [CHAN_W-1:0] q;
        logic [CHAN_W:0]   s;
        t = {1'b0, p} + (2*CHAN_W+1)'(1) + (2*CHAN_W+1)'(p >> CHAN_W);
        q = t[2*CHAN_W-1:CHAN_W];
        s = {1'b0, q} + {1'b0, offset};
        return s[CHAN_W] ? {CHAN_W{1'b1}} : s[CHAN_W-1:0];
    endfunction

endpackage

[rtl/cmrm_ram.sv]
// generic single write, single read port ram with registered read data
// no dependencies
module cmrm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/cmrm_front.sv]
// front end: accepts words, tracks line columns and banks, owns the line store
// depends on cmrm_pkg and cmrm_ram
module cmrm_front
    import cmrm_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      operation,
    input  logic [CHAN_W-1:0]         red,
    input  logic [CHAN_W-1:0]         green,
    input  logic [CHAN_W-1:0]         blue,
    input  logic [LINE_WIDTH_W-1:0]   line_width,
    input  logic [$clog2(Q_DEPTH+1)-1:0] q_count,
    output logic                      pix_valid,
    output pix_t                      pix
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW  = CW + 1;
    localparam int EW  = (WW > LINE_WIDTH_W) ? WW : LINE_WIDTH_W;
    localparam int AW  = $clog2(2 * MAX_WIDTH);
    localparam int QCW = $clog2(Q_DEPTH + 1);

    logic [CW-1:0] wc_reg, wc_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic          bank_reg, bank_next;
    logic          pend_reg, pend_next;
    logic          s1_valid_reg;
    logic          s1_eol_reg;

    logic          accept;
    logic [EW-1:0] lw_ext;
    logic [EW-1:0] w_full;
    logic [WW-1:0] w;
    logic [WW-1:0] rc_ext;
    logic [WW-1:0] wc_ext;
    logic          rel;
    logic          rel_eol;
    logic          wr_en;
    logic [CW-1:0] rd_col;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [3*CHAN_W-1:0] wr_data;
    logic [3*CHAN_W-1:0] rd_data;

    assign in_ready = ((QCW+1)'(q_count) + (QCW+1)'(s1_valid_reg)) < (QCW+1)'(Q_DEPTH);
    assign accept   = in_valid && in_ready;

    // out of range widths clamp to 1 .. MAX_WIDTH
    assign lw_ext = EW'(line_width);
    assign w_full = (lw_ext == '0) ? EW'(1)
                  : (lw_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : lw_ext;
    assign w      = w_full[WW-1:0];
    assign rc_ext = {1'b0, rc_reg};
    assign wc_ext = {1'b0, wc_reg};

    always_comb
    begin
        wc_next   = wc_reg;
        rc_next   = rc_reg;
        bank_next = bank_reg;
        pend_next = pend_reg;
        rel       = 1'b0;
        rel_eol   = 1'b0;
        wr_en     = 1'b0;
        rd_col    = '0;
        if (accept)
        begin
            if (pend_reg)
            begin
                if (rc_ext >= w)
                begin
                    pend_next = 1'b0;
                    rc_next   = '0;
                end
                else
                begin
                    rel     = 1'b1;
                    rd_col  = CW'(w - WW'(1) - rc_ext);
                    rel_eol = (rc_ext == w - WW'(1));
                    if (rc_ext + WW'(1) >= w)
                    begin
                        rc_next   = '0;
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        rc_next = rc_reg + CW'(1);
                    end
                end
            end
            if (op_t'(operation) == OP_PIXEL)
            begin
                wr_en = 1'b1;
                if (wc_ext + WW'(1) >= w)
                begin
                    wc_next   = '0;
                    bank_next = ~bank_reg;
                    rc_next   = '0;
                    pend_next = 1'b1;
                end
                else
                begin
                    wc_next = wc_reg + CW'(1);
                end
            end
        end
    end

    // read the bank not being filled
    assign rd_addr = AW'(rd_col) + (bank_reg ? AW'(0) : AW'(MAX_WIDTH));
    assign wr_addr = AW'(wc_reg) + (bank_reg ? AW'(MAX_WIDTH) : AW'(0));
    assign wr_data = {~red, ~green, ~blue};

    cmrm_ram #(
        .WIDTH (3 * CHAN_W),
        .DEPTH (2 * MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rel),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg       <= '0;
            rc_reg       <= '0;
            bank_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            wc_reg       <= wc_next;
            rc_reg       <= rc_next;
            bank_reg     <= bank_next;
            pend_reg     <= pend_next;
            s1_valid_reg <= rel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rel)
        begin
            s1_eol_reg <= rel_eol;
        end
    end

    assign pix_valid = s1_valid_reg;
    assign pix.c     = rd_data[3*CHAN_W-1:2*CHAN_W];
    assign pix.m     = rd_data[2*CHAN_W-1:CHAN_W];
    assign pix.y     = rd_data[CHAN_W-1:0];
    assign pix.eol   = s1_eol_reg;

endmodule

[rtl/cmrm_queue.sv]
// short first-in first-out queue of released pixels between front and back
// depends on cmrm_pkg
module cmrm_queue
    import cmrm_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  pix_t                       push_data,
    input  logic                       pop,
    output pix_t                       pop_data,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    pix_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

[rtl/cmrm_back.sv]
// back end: gain multiply stage, divide by 255 with offset and saturation, output register
// depends on cmrm_pkg
module cmrm_back
    import cmrm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  pix_t              q_data,
    output logic              q_pop,
    input  scale_cfg_t        scale_cfg,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAN_W-1:0] cyan,
    output logic [CHAN_W-1:0] magenta,
    output logic [CHAN_W-1:0] yellow,
    output logic              end_of_line
);

    logic                m_valid_reg;
    logic [2*CHAN_W-1:0] m_c_reg;
    logic [2*CHAN_W-1:0] m_m_reg;
    logic [2*CHAN_W-1:0] m_y_reg;
    logic                m_eol_reg;
    logic                o_valid_reg;
    logic [CHAN_W-1:0]   o_c_reg;
    logic [CHAN_W-1:0]   o_m_reg;
    logic [CHAN_W-1:0]   o_y_reg;
    logic                o_eol_reg;
    logic                o_load;
    logic                m_load;

    assign o_load = !o_valid_reg || out_ready;
    assign m_load = !m_valid_reg || o_load;
    assign q_pop  = m_load && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_load)
            begin
                m_valid_reg <= q_valid;
            end
            if (o_load)
            begin
                o_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            m_c_reg   <= q_data.c * scale_cfg.cyan_gain;
            m_m_reg   <= q_data.m * scale_cfg.magenta_gain;
            m_y_reg   <= q_data.y * scale_cfg.yellow_gain;
            m_eol_reg <= q_data.eol;
        end
        if (o_load && m_valid_reg)
        begin
            o_c_reg   <= scale_chan(m_c_reg, scale_cfg.cyan_offset);
            o_m_reg   <= scale_chan(m_m_reg, scale_cfg.magenta_offset);
            o_y_reg   <= scale_chan(m_y_reg, scale_cfg.yellow_offset);
            o_eol_reg <= m_eol_reg;
        end
    end

    assign out_valid   = o_valid_reg;
    assign cyan        = o_c_reg;
    assign magenta     = o_m_reg;
    assign yellow      = o_y_reg;
    assign end_of_line = o_eol_reg;

endmodule

[rtl/cmy_mirror_range_map_unit.sv]
// top level of the mirrored cmy range map: configuration registers and wiring
// depends on cmrm_pkg, cmrm_front, cmrm_queue and cmrm_back
//
// usage
//   input channel (in_valid/in_ready): one word per pixel in raster order, operation
//   selects a pixel store (which also releases one mirrored pixel of the previous
//   line) or a flush (release only, drains the last line)
//   output channel (out_valid/out_ready): zero or one word per input word, cmy of the
//   mirrored pixel scaled by gain/255 plus offset, end_of_line on the last of a line
//   configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready,
//   write only while the block is idle
//   throughput: one word per clock in each direction while out_ready is high, set
//   by the line store which takes one write and one read per cycle
//   path to output valid: store read at the accepting edge, then queue, gain
//   multiply, divide and saturate into the output register
//   reset: registers take their default values, no line pending, both banks
//   undefined; the first line produces no output while it is stored
//   receiver stall: the output register holds, the back end and a 4 word queue fill,
//   then in_ready drops until room frees up
module cmy_mirror_range_map_unit
    import cmrm_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    operation,
    input  logic [CHAN_W-1:0]       red,
    input  logic [CHAN_W-1:0]       green,
    input  logic [CHAN_W-1:0]       blue,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHAN_W-1:0]       cyan,
    output logic [CHAN_W-1:0]       magenta,
    output logic [CHAN_W-1:0]       yellow,
    output logic                    end_of_line,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [LINE_WIDTH_W-1:0] cfg_data
);

    localparam int QCW = $clog2(Q_DEPTH + 1);

    logic [LINE_WIDTH_W-1:0] line_width_reg;
    scale_cfg_t              scale_cfg_reg;
    logic                    pix_valid;
    pix_t                    pix;
    pix_t                    q_data;
    logic                    q_valid;
    logic                    q_pop;
    logic [QCW-1:0]          q_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg               <= LINE_WIDTH_RST;
            scale_cfg_reg.cyan_gain      <= CYAN_GAIN_RST;
            scale_cfg_reg.cyan_offset    <= CYAN_OFFSET_RST;
            scale_cfg_reg.magenta_gain   <= MAGENTA_GAIN_RST;
            scale_cfg_reg.magenta_offset <= MAGENTA_OFFSET_RST;
            scale_cfg_reg.yellow_gain    <= YELLOW_GAIN_RST;
            scale_cfg_reg.yellow_offset  <= YELLOW_OFFSET_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LINE_WIDTH:     line_width_reg <= cfg_data;
                CFG_CYAN_GAIN:      scale_cfg_reg.cyan_gain <= cfg_data[CHAN_W-1:0];
                CFG_CYAN_OFFSET:    scale_cfg_reg.cyan_offset <= cfg_data[CHAN_W-1:0];
                CFG_MAGENTA_GAIN:   scale_cfg_reg.magenta_gain <= cfg_data[CHAN_W-1:0];
                CFG_MAGENTA_OFFSET: scale_cfg_reg.magenta_offset <= cfg_data[CHAN_W-1:0];
                CFG_YELLOW_GAIN:    scale_cfg_reg.yellow_gain <= cfg_data[CHAN_W-1:0];
                CFG_YELLOW_OFFSET:  scale_cfg_reg.yellow_offset <= cfg_data[CHAN_W-1:0];
                default:            ;
            endcase
        end
    end

    cmrm_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .line_width (line_width_reg),
        .q_count    (q_count),
        .pix_valid  (pix_valid),
        .pix        (pix)
    );

    cmrm_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pix_valid),
        .push_data (pix),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid),
        .count     (q_count)
    );

    cmrm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .scale_cfg   (scale_cfg_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cyan        (cyan),
        .magenta     (magenta),
        .yellow      (yellow),
        .end_of_line (end_of_line)
    );

endmodule

[rtl/cmrm_checker.sv]
// port level checks of the mirrored cmy range map, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module cmrm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] cyan,
    input logic [7:0] magenta,
    input logic [7:0] yellow,
    input logic       end_of_line,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    `CMRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(cyan) && $stable(magenta) && $stable(yellow)
        && $stable(end_of_line),
        "output word changed while stalled")

    `CMRM_ASSERT_ALWAYS(a_no_word_after_reset, !$rose(rst_n) || !out_valid,
        "output word present straight after reset")

    `CMRM_ASSERT_ALWAYS(a_cfg_always_ready, !cfg_valid || cfg_ready,
        "configuration write refused")

endmodule

bind cmy_mirror_range_map_unit cmrm_checker u_checker (.*);
